### sv/printf_subset_formatter_core_defines.svh
// Assertion macros for the formatter core.
`ifndef PRINTF_SUBSET_FORMATTER_CORE_DEFINES_SVH
`define PRINTF_SUBSET_FORMATTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PSF_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define PSF_ASSERT(label, clk, rst_n, prop)
`define PSF_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### sv/psf_pkg.sv
`default_nettype none
package psf_pkg;
  localparam int unsigned BufferSizeDefault = 256;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_DEC,
    OP_SDEC,
    OP_HEX,
    OP_BAD,
    OP_DONE,
    OP_BADDONE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
    logic [31:0] arg;
  } cmd_t;

  localparam logic [7:0] ChPct  = 8'h25;
  localparam logic [7:0] ChLowD = 8'h64;
  localparam logic [7:0] ChLowU = 8'h75;
  localparam logic [7:0] ChLowX = 8'h78;
  localparam logic [7:0] ChLowC = 8'h63;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChLf   = 8'h0a;

  function automatic logic [7:0] bad_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h5b;
      3'd1: c = 8'h42;
      3'd2: c = 8'h41;
      3'd3: c = 8'h44;
      3'd4: c = 8'h46;
      3'd5: c = 8'h4d;
      3'd6: c = 8'h54;
      default: c = 8'h5d;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

### sv/psf_front.sv
`default_nettype none
// Classifies format bytes into commands; tracks the pending '%'.
module psf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [7:0]         fmt_char_i,
  input  wire logic [31:0]        arg_value_i,
  output logic                    cmd_valid_o,
  output psf_pkg::cmd_t           cmd_o,
  input  wire logic               cmd_ready_i
);
  logic expect_q, expect_d;
  logic acc;
  psf_pkg::cmd_t cmd;
  logic emit;

  assign full_o = !cmd_ready_i;
  assign acc = push_i && cmd_ready_i;

  always_comb begin
    cmd.ch  = fmt_char_i;
    cmd.arg = arg_value_i;
    cmd.op  = psf_pkg::OP_CHAR;
    emit    = 1'b1;
    expect_d = expect_q;
    if (!expect_q) begin
      if (fmt_char_i == 8'd0) begin
        cmd.op = psf_pkg::OP_DONE;
      end else if (fmt_char_i == psf_pkg::ChPct) begin
        emit = 1'b0;
        expect_d = 1'b1;
      end
    end else begin
      expect_d = 1'b0;
      unique case (fmt_char_i)
        8'd0:           cmd.op = psf_pkg::OP_BADDONE;
        psf_pkg::ChLowD: cmd.op = psf_pkg::OP_SDEC;
        psf_pkg::ChLowU: cmd.op = psf_pkg::OP_DEC;
        psf_pkg::ChLowX: cmd.op = psf_pkg::OP_HEX;
        psf_pkg::ChLowC: cmd.ch = arg_value_i[7:0];
        psf_pkg::ChPct:  cmd.ch = psf_pkg::ChPct;
        default:        cmd.op = psf_pkg::OP_BAD;
      endcase
    end
  end

  assign cmd_valid_o = acc && emit;
  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b0;
    end else if (acc) begin
      expect_q <= expect_d;
    end
  end
endmodule
`default_nettype wire

### sv/psf_fifo.sv
`default_nettype none
// Small command queue between front and back.
module psf_fifo #(
  parameter int unsigned Depth = psf_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire psf_pkg::cmd_t wdata_i,
  output logic               ready_o,
  output logic               valid_o,
  output psf_pkg::cmd_t      rdata_o,
  input  wire logic          rd_i
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  psf_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic do_wr, do_rd;

  assign ready_o = cnt_q != (AW+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];
  assign do_wr = wr_i && ready_o;
  assign do_rd = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end
endmodule
`default_nettype wire

### sv/psf_back.sv
`default_nettype none
// Executes: shift-and-add-3 decimal conversion, then one character per cycle if popped.
module psf_back #(
  parameter int unsigned BufferSize = psf_pkg::BufferSizeDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire psf_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [7:0]         out_char_o,
  output logic [7:0]         char_count_o,
  output logic               done_res_o,
  output logic               last_o
);
  localparam int unsigned LimRaw = (BufferSize > 1) ? BufferSize - 1 : 0;
  localparam logic [7:0] Limit = (LimRaw > 255) ? 8'd255 : 8'(LimRaw);

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_LEN, S_MINUS, S_DIG, S_BAD, S_CR, S_OUT
  } state_e;

  state_e          state_q;
  logic [7:0]      count_q;
  logic            hidden_q;
  logic [31:0]     work_q;
  logic [4:0]      bit_q;
  logic [9:0][3:0] dig_q;
  logic [3:0]      nd_q;
  logic            neg_q;
  logic [2:0]      bi_q;
  logic            bad_done_q;
  logic            ovalid_q;
  logic [7:0]      och_q, ocnt_q;
  logic            odone_q, olast_q;

  logic            oslot;
  logic            go;
  logic [39:0]     dd_adj_w;
  logic [9:0][3:0] dd_next;

  logic            pc_store, pc_show, pc_lf, pc_lim;
  logic [7:0]      pc_cnt;
  logic [7:0]      cur_ch;
  logic            cur_last;
  logic            emit;
  logic [7:0]      e_ch, e_cnt;
  logic            e_done, e_last;

  function automatic logic [7:0] dchar(input logic [3:0] d);
    return (d < 4'd10) ? psf_pkg::ChZero + {4'd0, d}
                       : psf_pkg::ChLowA + {4'd0, d - 4'd10};
  endfunction

  // add 3 to every BCD digit of 5 or more before the next shift
  function automatic logic [39:0] dd_adj(input logic [39:0] b);
    logic [39:0] r;
    r = b;
    for (int i = 0; i < 10; i++) begin
      if (b[4*i +: 4] >= 4'd5) r[4*i +: 4] = b[4*i +: 4] + 4'd3;
    end
    return r;
  endfunction

  // significant digits, at least one
  function automatic logic [3:0] dlen(input logic [9:0][3:0] d);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 10; i++) begin
      if (d[i] != 4'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

  assign oslot = !ovalid_q || pop_i;
  assign go = (state_q == S_IDLE) && cmd_valid_i && oslot;
  assign cmd_pop_o = go;
  assign empty_o = !ovalid_q;
  assign out_char_o = och_q;
  assign char_count_o = ocnt_q;
  assign done_res_o = odone_q;
  assign last_o = olast_q;

  assign dd_adj_w = dd_adj(dig_q);
  assign dd_next = {dd_adj_w[38:0], work_q[31]};

  // one put_char step and the result it loads
  always_comb begin
    cur_ch = 8'd0;
    case (state_q)
      S_IDLE:  cur_ch = cmd_i.ch;
      S_MINUS: cur_ch = psf_pkg::ChMinus;
      S_DIG:   cur_ch = dchar(dig_q[nd_q - 4'd1]);
      S_BAD:   cur_ch = psf_pkg::bad_char(bi_q);
      default: ;
    endcase
    pc_store = count_q < Limit;
    pc_cnt = count_q + 8'd1;
    // this character fills the buffer: the rest of the item is dropped
    pc_lim = pc_cnt == Limit;
    pc_show = pc_store && !hidden_q && (cur_ch != 8'd0);
    pc_lf = cur_ch == psf_pkg::ChLf;
    case (state_q)
      S_MINUS: cur_last = pc_lim;
      S_DIG:   cur_last = (nd_q == 4'd1) || pc_lim;
      S_BAD:   cur_last = !bad_done_q && ((bi_q == 3'd7) || pc_lim);
      default: cur_last = 1'b1;
    endcase

    emit = 1'b0;
    e_ch = cur_ch;
    e_cnt = pc_cnt;
    e_done = 1'b0;
    e_last = cur_last;
    case (state_q)
      S_IDLE: if (go) begin
        if (cmd_i.op == psf_pkg::OP_CHAR && pc_show) begin
          emit = 1'b1;
          if (pc_lf) begin
            e_ch = psf_pkg::ChCr;
            e_last = 1'b0;
          end
        end else if (cmd_i.op == psf_pkg::OP_DONE) begin
          emit = 1'b1;
          e_ch = 8'd0;
          e_cnt = count_q;
          e_done = 1'b1;
          e_last = 1'b1;
        end
      end
      S_MINUS, S_DIG, S_BAD: emit = oslot && pc_show;
      S_CR: begin
        emit = oslot;
        e_ch = psf_pkg::ChLf;
        e_cnt = ocnt_q;
        e_last = 1'b1;
      end
      S_OUT: begin
        emit = oslot;
        e_ch = 8'd0;
        e_cnt = count_q;
        e_done = 1'b1;
        e_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      hidden_q <= 1'b0;
      work_q <= '0;
      bit_q <= '0;
      dig_q <= '0;
      nd_q <= '0;
      neg_q <= 1'b0;
      bi_q <= '0;
      bad_done_q <= 1'b0;
      ovalid_q <= 1'b0;
      och_q <= '0;
      ocnt_q <= '0;
      odone_q <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      if (emit) begin
        ovalid_q <= 1'b1;
        och_q <= e_ch;
        ocnt_q <= e_cnt;
        odone_q <= e_done;
        olast_q <= e_last;
      end else if (pop_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (go) begin
          bad_done_q <= cmd_i.op == psf_pkg::OP_BADDONE;
          bi_q <= '0;
          bit_q <= '0;
          neg_q <= (cmd_i.op == psf_pkg::OP_SDEC) && cmd_i.arg[31];
          case (cmd_i.op) inside
            psf_pkg::OP_CHAR: if (pc_store) begin
              count_q <= pc_cnt;
              if (cur_ch == 8'd0) hidden_q <= 1'b1;
              if (pc_show && pc_lf) state_q <= S_CR;
            end
            psf_pkg::OP_DONE: begin
              count_q <= '0;
              hidden_q <= 1'b0;
            end
            psf_pkg::OP_BAD, psf_pkg::OP_BADDONE: state_q <= S_BAD;
            psf_pkg::OP_HEX: begin
              // hex digits are the nibbles themselves
              dig_q <= {8'd0, cmd_i.arg};
              state_q <= S_LEN;
            end
            psf_pkg::OP_DEC, psf_pkg::OP_SDEC: begin
              work_q <= (cmd_i.op == psf_pkg::OP_SDEC && cmd_i.arg[31])
                        ? ~cmd_i.arg + 32'd1 : cmd_i.arg;
              dig_q <= '0;
              state_q <= S_CONV;
            end
            default: ;
          endcase
        end
        S_CONV: begin
          dig_q <= dd_next;
          work_q <= {work_q[30:0], 1'b0};
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'd31) state_q <= S_LEN;
        end
        S_LEN: begin
          nd_q <= dlen(dig_q);
          state_q <= neg_q ? S_MINUS : S_DIG;
        end
        S_MINUS, S_DIG, S_BAD: if (oslot) begin
          if (pc_store) count_q <= pc_cnt;
          if (state_q == S_MINUS) begin
            state_q <= S_DIG;
          end else if (state_q == S_DIG) begin
            nd_q <= nd_q - 4'd1;
            if (nd_q == 4'd1) state_q <= S_IDLE;
          end else begin
            bi_q <= bi_q + 3'd1;
            if (bi_q == 3'd7) state_q <= bad_done_q ? S_OUT : S_IDLE;
          end
        end
        S_CR: if (oslot) state_q <= S_IDLE;
        S_OUT: if (oslot) begin
          count_q <= '0;
          hidden_q <= 1'b0;
          bad_done_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/printf_subset_formatter_core.sv
// A plain byte's command passes through the command queue and the registered result stage;
// %u/%d run a shift-and-add-3 conversion, then size the number (worst %d: sign, 10 digits).
// The back end emits at most one result per cycle while results are taken; it takes no new
// command until the current one is done; a full 4-entry queue raises full.
// Reset: asynchronous, active low; clears count, hidden flag, pending '%' and queues.
`default_nettype none
`include "printf_subset_formatter_core_defines.svh"
module printf_subset_formatter_core #(
  parameter int unsigned BufferSize = psf_pkg::BufferSizeDefault,
  parameter int unsigned QueueDepth = psf_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  fmt_char_i,
  input  wire logic [31:0] arg_value_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_char_o,
  output logic [7:0]       char_count_o,
  output logic             done_res_o,
  output logic             last_o
);
  // front: classify; queue: decouple; back: convert and emit
  logic          f_valid, q_ready, q_valid, b_pop;
  psf_pkg::cmd_t f_cmd, q_cmd;

  psf_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .fmt_char_i, .arg_value_i,
    .cmd_valid_o(f_valid), .cmd_o(f_cmd), .cmd_ready_i(q_ready)
  );

  psf_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .wr_i(f_valid), .wdata_i(f_cmd), .ready_o(q_ready),
    .valid_o(q_valid), .rdata_o(q_cmd), .rd_i(b_pop)
  );

  psf_back #(.BufferSize(BufferSize)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(q_cmd), .cmd_pop_o(b_pop),
    .empty_o(empty), .pop_i(pop), .out_char_o, .char_count_o, .done_res_o, .last_o
  );

  // closing result always ends the item's results
  `PSF_ASSERT(a_done_last, clk_i, rst_ni, (!empty && done_res_o) |-> last_o)
  // closing result carries a NUL
  `PSF_ASSERT(a_done_nul, clk_i, rst_ni, (!empty && done_res_o) |-> out_char_o == 8'd0)
  // a waiting result holds while not taken
  `PSF_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_char_o)))
endmodule
`default_nettype wire
